// File: src/q2r_pkg.sv
// Package for the quaternion to rotation matrix core: widths and result types.
// No dependencies.
`default_nettype none
package q2r_pkg;
  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_WIDTH     = 16;
  localparam int N_ENTRIES     = 9;
  typedef logic signed [OUT_WIDTH-1:0] entry_t;
  typedef entry_t [N_ENTRIES-1:0] matrix_t;
endpackage
`default_nettype wire

// File: src/quaternion_to_rotation_matrix_core.sv
// Top level of the quaternion to rotation matrix core with output register.
// Depends on q2r_pkg, q2r_prod, q2r_div.
`default_nettype none
// Takes one quaternion request per cycle and returns the nine rotation matrix
// entries in Q2.14, each the exact ratio num/n2 rounded to nearest, ties away
// from zero, so no square root or normalization is needed. An all-zero
// quaternion sets zero_error and returns the identity. The pipeline has two
// product/numerator stages, FRAC_BITS + 2 divider stages and one output
// register; the fully pipelined divider resolves one quotient bit per stage,
// then rounds. It advances, taking one request per cycle, whenever the
// output register is free or being taken.
module quaternion_to_rotation_matrix_core #(
  parameter int IN_WIDTH  = q2r_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = q2r_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [4*IN_WIDTH-1:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [143:0]         m_tdata,   // r0c0 .. r2c2, 16 bits each
  output logic                 m_tuser    // zero_error
);
  localparam int NW = 2*IN_WIDTH + 4;
  logic en;
  logic pv, dv, dz;
  logic signed [NW-1:0] num [9];
  logic [NW-1:0] den;
  logic zr;
  q2r_pkg::matrix_t mat;
  // stall everything when the output holds an untaken result
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  q2r_prod #(.IN_WIDTH(IN_WIDTH), .NW(NW)) u_prod (
    .clk, .rst, .en, .in_valid(s_tvalid),
    .qx(s_tdata[IN_WIDTH-1:0]), .qy(s_tdata[2*IN_WIDTH-1:IN_WIDTH]),
    .qz(s_tdata[3*IN_WIDTH-1:2*IN_WIDTH]), .qw(s_tdata[4*IN_WIDTH-1:3*IN_WIDTH]),
    .out_valid(pv), .num, .den, .zero(zr));
  q2r_div #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_div (
    .clk, .rst, .en, .in_valid(pv), .num, .den, .zero(zr),
    .out_valid(dv), .mat, .zero_out(dz));
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv;
    if (en) begin
      m_tdata <= mat;
      m_tuser <= dz;
    end
  end
`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("lost result");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");
  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:16] == 16'd0) else $error("zero not identity");
`endif
endmodule
`default_nettype wire

// File: src/q2r_prod.sv
// Front end: component products, norm and the nine numerators, registered.
// Depends on q2r_pkg.
`default_nettype none
module q2r_prod #(
  parameter int IN_WIDTH = q2r_pkg::IN_WIDTH_DEF,
  parameter int NW       = 2*IN_WIDTH + 4
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        en,
  input  wire                        in_valid,
  input  wire signed [IN_WIDTH-1:0]  qx,
  input  wire signed [IN_WIDTH-1:0]  qy,
  input  wire signed [IN_WIDTH-1:0]  qz,
  input  wire signed [IN_WIDTH-1:0]  qw,
  output logic                       out_valid,
  output logic signed [NW-1:0]       num [9],
  output logic        [NW-1:0]       den,
  output logic                       zero
);
  localparam int PW = 2*IN_WIDTH;
  // stage A: products
  logic signed [PW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  logic                 va;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
    if (en) begin
      xx <= qx*qx; yy <= qy*qy; zz <= qz*qz; ww <= qw*qw;
      xy <= qx*qy; xz <= qx*qz; yz <= qy*qz;
      wx <= qw*qx; wy <= qw*qy; wz <= qw*qz;
    end
  end
  function automatic logic signed [NW-1:0] ext(input logic signed [PW-1:0] v);
    ext = NW'(v);
  endfunction
  logic signed [NW-1:0] n2;
  assign n2 = ext(xx) + ext(yy) + ext(zz) + ext(ww);
  // stage B: numerators
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= va;
    if (en) begin
      num[0] <= n2 - ((ext(yy) + ext(zz)) <<< 1);
      num[1] <= (ext(xy) + ext(wz)) <<< 1;
      num[2] <= (ext(xz) - ext(wy)) <<< 1;
      num[3] <= (ext(xy) - ext(wz)) <<< 1;
      num[4] <= n2 - ((ext(xx) + ext(zz)) <<< 1);
      num[5] <= (ext(yz) + ext(wx)) <<< 1;
      num[6] <= (ext(xz) + ext(wy)) <<< 1;
      num[7] <= (ext(yz) - ext(wx)) <<< 1;
      num[8] <= n2 - ((ext(xx) + ext(yy)) <<< 1);
      den    <= n2;
      zero   <= (n2 == '0);
    end
  end
endmodule
`default_nettype wire

// File: src/q2r_div.sv
// Pipelined restoring divider: one quotient bit per stage for the nine
// entries in parallel, then rounding. Depends on q2r_pkg.
`default_nettype none
module q2r_div #(
  parameter int FRAC_BITS = q2r_pkg::FRAC_BITS_DEF,
  parameter int NW        = 36
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire                   in_valid,
  input  wire signed [NW-1:0]   num [9],
  input  wire        [NW-1:0]   den,
  input  wire                   zero,
  output logic                  out_valid,
  output q2r_pkg::matrix_t      mat,
  output logic                  zero_out
);
  localparam int ST = FRAC_BITS + 2;  // integer bit, fraction bits, round
  localparam int QW = FRAC_BITS + 2;
  logic [NW:0]   rem [1:ST][9];
  logic [QW-1:0] quo [1:ST][9];
  logic          neg [1:ST][9];
  logic [NW-1:0] dd  [1:ST];
  logic          vz  [1:ST];
  logic          vv  [1:ST];
  for (genvar s = 0; s < ST; s++) begin : g_st
    logic [NW:0]   r2      [9];
    logic [NW:0]   cur_rem [9];
    logic [QW-1:0] cur_quo [9];
    logic          cur_neg [9];
    logic [NW-1:0] cur_dd;
    logic          cur_vz;
    logic          cur_vv;
    if (s == 0) begin : g_in
      // magnitude and sign of each numerator enter the first stage
      always_comb begin
        cur_dd = den; cur_vz = zero; cur_vv = in_valid;
        for (int e = 0; e < 9; e++) begin
          cur_neg[e] = num[e][NW-1];
          cur_rem[e] = cur_neg[e] ? (NW+1)'(-num[e]) : (NW+1)'(num[e]);
          cur_quo[e] = '0;
        end
      end
    end else begin : g_mid
      always_comb begin
        cur_dd = dd[s]; cur_vz = vz[s]; cur_vv = vv[s];
        for (int e = 0; e < 9; e++) begin
          cur_neg[e] = neg[s][e];
          cur_rem[e] = rem[s][e];
          cur_quo[e] = quo[s][e];
        end
      end
    end
    always_comb
      for (int e = 0; e < 9; e++)
        r2[e] = (s == 0) ? cur_rem[e] : (cur_rem[e] << 1);
    always_ff @(posedge clk) begin
      if (rst) vv[s+1] <= 1'b0;
      else if (en) vv[s+1] <= cur_vv;
      if (en) begin
        dd[s+1] <= cur_dd;
        vz[s+1] <= cur_vz;
        for (int e = 0; e < 9; e++) begin
          neg[s+1][e] <= cur_neg[e];
          if (r2[e] >= {1'b0, cur_dd}) begin
            rem[s+1][e] <= (s == ST-1) ? cur_rem[e] : r2[e] - {1'b0, cur_dd};
            quo[s+1][e] <= (s == ST-1) ? cur_quo[e] + 1'b1 : {cur_quo[e][QW-2:0], 1'b1};
          end else begin
            rem[s+1][e] <= (s == ST-1) ? cur_rem[e] : r2[e];
            quo[s+1][e] <= (s == ST-1) ? cur_quo[e] : {cur_quo[e][QW-2:0], 1'b0};
          end
        end
      end
    end
  end
  always_comb begin
    out_valid = vv[ST];
    zero_out  = vz[ST];
    for (int e = 0; e < 9; e++) begin
      if (vz[ST])
        mat[e] = (e == 0 || e == 4 || e == 8) ?
                 q2r_pkg::OUT_WIDTH'(64'd1 << FRAC_BITS) : '0;
      else
        mat[e] = neg[ST][e] ? q2r_pkg::OUT_WIDTH'(-{1'b0, quo[ST][e]})
                            : q2r_pkg::OUT_WIDTH'({1'b0, quo[ST][e]});
    end
  end
endmodule
`default_nettype wire

// File: tb/sv/quaternion_to_rotation_matrix_core_tb.sv
// Testbench for quaternion_to_rotation_matrix_core: directed and random quaternions,
// rounded-ratio matrix predictor, random idling on both stream sides.
// Depends on q2r_pkg and the core RTL.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_core_tb;

  localparam int LATENCY = q2r_pkg::FRAC_BITS_DEF + 5;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    q2r_pkg::matrix_t mat;
    logic             zero_err;
  } rot_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;        // r0c0 .. r2c2
  logic         m_tuser;        // zero_error

  rot_result_t  expected_mats[$];
  int           error_count = 0;
  longint       cycle_count = 0;
  bit           idle_enable = 1'b1;

  quaternion_to_rotation_matrix_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // round(num * 2^FRAC / den), ties away from zero; wraps to 16 bits
  function automatic q2r_pkg::entry_t fixed_ratio(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    logic signed [127:0] rem;
    mag = (num < 0) ? -num : num;
    q = (mag <<< q2r_pkg::FRAC_BITS_DEF) / den;
    rem = (mag <<< q2r_pkg::FRAC_BITS_DEF) % den;
    if (2 * rem >= den) q = q + 1;
    if (num < 0) q = -q;
    return q[q2r_pkg::OUT_WIDTH-1:0];
  endfunction

  function automatic rot_result_t rotation_of(input logic [63:0] quat);
    rot_result_t r;
    logic signed [127:0] x, y, z, w, n2;
    x = 128'($signed(quat[15:0]));
    y = 128'($signed(quat[31:16]));
    z = 128'($signed(quat[47:32]));
    w = 128'($signed(quat[63:48]));
    n2 = x*x + y*y + z*z + w*w;
    r = '0;
    if (n2 == 0) begin
      r.mat[0] = q2r_pkg::entry_t'(1 << q2r_pkg::FRAC_BITS_DEF);
      r.mat[4] = q2r_pkg::entry_t'(1 << q2r_pkg::FRAC_BITS_DEF);
      r.mat[8] = q2r_pkg::entry_t'(1 << q2r_pkg::FRAC_BITS_DEF);
      r.zero_err = 1'b1;
    end else begin
      r.mat[0] = fixed_ratio(n2 - 2*(y*y + z*z), n2);
      r.mat[1] = fixed_ratio(2*(x*y + w*z), n2);
      r.mat[2] = fixed_ratio(2*(x*z - w*y), n2);
      r.mat[3] = fixed_ratio(2*(x*y - w*z), n2);
      r.mat[4] = fixed_ratio(n2 - 2*(x*x + z*z), n2);
      r.mat[5] = fixed_ratio(2*(y*z + w*x), n2);
      r.mat[6] = fixed_ratio(2*(x*z + w*y), n2);
      r.mat[7] = fixed_ratio(2*(y*z - w*x), n2);
      r.mat[8] = fixed_ratio(n2 - 2*(x*x + y*y), n2);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Send one quaternion request, with an optional random gap first.
  // tvalid stays up after the accepting edge; a gap or a drain drops it.
  task automatic send_quat(input logic [15:0] x, y, z, w);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w, z, y, x};
    expected_mats.push_back(rotation_of({w, z, y, x}));
    do @(posedge clk); while (!s_tready);
  endtask

  // Sink side: random stall bursts, then ready for a stretch.
  initial begin
    @(negedge rst);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_mats.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        rot_result_t want;
        want = expected_mats.pop_front();
        for (int i = 0; i < q2r_pkg::N_ENTRIES; i++)
          if (m_tdata[16*i +: 16] !== want.mat[i])
            report_mismatch($sformatf("entry %0d", i),
                            int'($signed(m_tdata[16*i +: 16])), int'($signed(want.mat[i])));
        if (m_tuser !== want.zero_err)
          report_mismatch("zero_error", int'(m_tuser), int'(want.zero_err));
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_directed();
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);   // zero quaternion
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0001);   // identity
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);   // all most negative
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);   // exact ratios, no rounding
    send_quat(16'h0001, 16'h0002, 16'h0003, 16'h0004);
    send_quat(16'h0003, 16'h0000, 16'h0000, 16'h0003);
    send_quat(16'h7FFF, 16'h0001, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h7FFF);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random(input int count);
    logic [15:0] q[4];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 5))
          0: q[k] = 16'($urandom_range(0, 7) - 4);   // tiny magnitudes
          1: q[k] = ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
          2: q[k] = 16'h0000;
          default: q[k] = 16'($urandom);
        endcase
      end
      send_quat(q[0], q[1], q[2], q[3]);
    end
  endtask

  // Drop tvalid, then wait until every expected result is back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_mats.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();   // sender holds off until every result is back
    test_random(1500);
    idle_enable = 1'b0;
    test_random(300);   // back-to-back, no idling
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
src/q2r_pkg.sv
src/q2r_prod.sv
src/q2r_div.sv
src/quaternion_to_rotation_matrix_core.sv
tb/sv/quaternion_to_rotation_matrix_core_tb.sv
